/* design/msort_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_pkg
// Shared constants and types of the merge sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int MAX_ELEMS_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef struct packed {
        logic busy;
        logic done;
        logic src_sel;
    } msort_stat_t;

endpackage

/* design/msort_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    output logic [WIDTH-1:0] rdata0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

/* design/msort_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_merge
// Bottom-up merge sequencer: one compare and one write per element and pass,
// ping-ponging between the two buffers.
// ----------------------------------------------------------------------------
module msort_merge
    import msort_pkg::*;
#(
    parameter int MAX_ELEMS  = MAX_ELEMS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = $clog2(MAX_ELEMS),
    localparam int CW = $clog2(MAX_ELEMS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] data_l,
    input  logic [DATA_WIDTH-1:0] data_r,
    output logic [AW-1:0]         raddr_l,
    output logic [AW-1:0]         raddr_r,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data,
    output msort_stat_t           stat
);

    localparam int SW = CW + 2;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SEG,
        M_RD,
        M_CMP
    } mstate_t;

    mstate_t       state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] rw_reg, rw_next;
    logic [CW-1:0] lp_reg, lp_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] op_reg, op_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] end_reg, end_next;
    logic          src_reg, src_next;
    logic          done_reg, done_next;

    logic [SW-1:0] n_ext;
    logic [SW-1:0] sum_mid;
    logic [SW-1:0] sum_end;
    logic [SW-1:0] rw_dbl;
    logic [CW-1:0] op_inc;
    logic          take_left;

    assign n_ext   = SW'(n_reg);
    assign sum_mid = SW'(op_reg) + rw_reg;
    assign sum_end = sum_mid + rw_reg;
    assign rw_dbl  = rw_reg << 1;
    assign op_inc  = op_reg + CW'(1);

    assign take_left = (lp_reg < mid_reg)
                       && ((rp_reg >= end_reg)
                           || ($signed(data_l) <= $signed(data_r)));

    assign raddr_l = lp_reg[AW-1:0];
    assign raddr_r = rp_reg[AW-1:0];
    assign wr_en   = (state_reg == M_CMP);
    assign wr_addr = op_reg[AW-1:0];
    assign wr_data = take_left ? data_l : data_r;

    assign stat.busy    = (state_reg != M_IDLE);
    assign stat.done    = done_reg;
    assign stat.src_sel = src_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        rw_next    = rw_reg;
        lp_next    = lp_reg;
        rp_next    = rp_reg;
        op_next    = op_reg;
        mid_next   = mid_reg;
        end_next   = end_reg;
        src_next   = src_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    n_next   = count;
                    rw_next  = SW'(1);
                    op_next  = '0;
                    src_next = 1'b0;
                    if (count <= CW'(1))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = M_SEG;
                    end
                end
            end
            M_SEG:
            begin
                mid_next   = (sum_mid > n_ext) ? n_reg : sum_mid[CW-1:0];
                end_next   = (sum_end > n_ext) ? n_reg : sum_end[CW-1:0];
                lp_next    = op_reg;
                rp_next    = mid_next;
                state_next = M_RD;
            end
            M_RD:
            begin
                state_next = M_CMP;
            end
            M_CMP:
            begin
                op_next = op_inc;
                if (take_left)
                begin
                    lp_next = lp_reg + CW'(1);
                end
                else
                begin
                    rp_next = rp_reg + CW'(1);
                end
                if (op_inc != end_reg)
                begin
                    state_next = M_RD;
                end
                else if (end_reg != n_reg)
                begin
                    state_next = M_SEG;
                end
                else
                begin
                    rw_next  = rw_dbl;
                    src_next = ~src_reg;
                    op_next  = '0;
                    if (rw_dbl >= n_ext)
                    begin
                        done_next  = 1'b1;
                        state_next = M_IDLE;
                    end
                    else
                    begin
                        state_next = M_SEG;
                    end
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            n_reg     <= '0;
            rw_reg    <= SW'(1);
            lp_reg    <= '0;
            rp_reg    <= '0;
            op_reg    <= '0;
            mid_reg   <= '0;
            end_reg   <= '0;
            src_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            rw_reg    <= rw_next;
            lp_reg    <= lp_next;
            rp_reg    <= rp_next;
            op_reg    <= op_next;
            mid_reg   <= mid_next;
            end_reg   <= end_next;
            src_reg   <= src_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* design/merge_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sorter
// Collects a set of signed values, sorts it ascending with a stable
// bottom-up merge sort and streams the sorted set out.
// ----------------------------------------------------------------------------
//  port group  | dir | beat contents
//  s_*         | in  | tdata: value; tlast: last element of the set
//  m_*         | out | tdata: sorted value; tlast: last of set; tuser: overflow
//
//  Loading takes one beat per cycle into buffer A.
//  Sorting runs ceil(log2 n) passes; per pass, each run pair has a setup
//  state and each element a read state and a compare-and-write state,
//  through one compare unit fed by the two-port read of the source buffer.
//  Each output beat is read, captured into a register and held until m_tready.
//  s_tready is low from the last beat of a set until its last result is taken.
//  Reset clears control state only; buffer contents need no clearing.
// ----------------------------------------------------------------------------
module merge_sorter
    import msort_pkg::*;
#(
    parameter int MAX_ELEMS  = MAX_ELEMS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [TDW-1:0] s_tdata,   // value
    input  logic           s_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [TDW-1:0] m_tdata,   // sorted_value
    output logic           m_tlast,
    output logic           m_tuser    // overflow
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = $clog2(MAX_ELEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SORT,
        S_ORD,
        S_OCAP,
        S_OWAIT
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  drop_reg, drop_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [DATA_WIDTH-1:0] odata_reg, odata_next;
    logic                  olast_reg, olast_next;

    logic                  load_we;
    logic                  s_beat;
    msort_stat_t           mstat;
    logic [AW-1:0]         m_raddr_l, m_raddr_r, m_waddr;
    logic                  m_we;
    logic [DATA_WIDTH-1:0] m_wdata;
    logic [DATA_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [DATA_WIDTH-1:0] src_l, src_r;
    logic                  a_we;
    logic [AW-1:0]         a_waddr, rd_addr0;
    logic [DATA_WIDTH-1:0] a_wdata;

    assign s_tready = (state_reg == S_LOAD);
    assign s_beat   = s_tvalid && s_tready;
    assign load_we  = s_beat && (count_reg < CW'(MAX_ELEMS));

    assign a_we     = load_we || (m_we && mstat.src_sel);
    assign a_waddr  = load_we ? count_reg[AW-1:0] : m_waddr;
    assign a_wdata  = load_we ? s_tdata[DATA_WIDTH-1:0] : m_wdata;
    assign rd_addr0 = (state_reg == S_ORD) ? k_reg[AW-1:0] : m_raddr_l;

    assign src_l = mstat.src_sel ? b_rd0 : a_rd0;
    assign src_r = mstat.src_sel ? b_rd1 : a_rd1;

    msort_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(MAX_ELEMS)
    ) u_buf_a (
        .clk    (clk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (a_wdata),
        .raddr0 (rd_addr0),
        .rdata0 (a_rd0),
        .raddr1 (m_raddr_r),
        .rdata1 (a_rd1)
    );

    msort_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(MAX_ELEMS)
    ) u_buf_b (
        .clk    (clk),
        .we     (m_we && !mstat.src_sel),
        .waddr  (m_waddr),
        .wdata  (m_wdata),
        .raddr0 (rd_addr0),
        .rdata0 (b_rd0),
        .raddr1 (m_raddr_r),
        .rdata1 (b_rd1)
    );

    msort_merge #(
        .MAX_ELEMS (MAX_ELEMS),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_START),
        .count   (count_reg),
        .data_l  (src_l),
        .data_r  (src_r),
        .raddr_l (m_raddr_l),
        .raddr_r (m_raddr_r),
        .wr_en   (m_we),
        .wr_addr (m_waddr),
        .wr_data (m_wdata),
        .stat    (mstat)
    );

    assign m_tvalid = (state_reg == S_OWAIT);
    assign m_tdata  = TDW'(odata_reg);
    assign m_tlast  = olast_reg;
    assign m_tuser  = drop_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        k_next     = k_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (s_beat)
                begin
                    if (load_we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_SORT;
            end
            S_SORT:
            begin
                if (mstat.done)
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                state_next = S_OCAP;
            end
            S_OCAP:
            begin
                odata_next = src_l;
                olast_next = ((k_reg + CW'(1)) == count_reg);
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (m_tready)
                begin
                    if (olast_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            k_reg     <= '0;
            odata_reg <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            k_reg     <= k_next;
            odata_reg <= odata_next;
            olast_reg <= olast_next;
        end
    end

endmodule

/* design/msort_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msort_chk
// Port-level checks of the merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module msort_chk
    import msort_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8
) (
    input logic           clk,
    input logic           rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic [TDW-1:0] s_tdata,
    input logic           s_tlast,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [TDW-1:0] m_tdata,
    input logic           m_tlast,
    input logic           m_tuser
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is shown");

    a_last_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still taken after the closing beat");

    a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("block not back to loading after the last result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind merge_sorter msort_chk #(.DATA_WIDTH(DATA_WIDTH)) u_msort_chk (.*);
